[hdl/pedf_pkg.sv]
// Shared types and constants for the periodic EDF task selector.
// No dependencies; imported by every module of the block.
package pedf_pkg;

	// Number of task slots held by the selector
	localparam int unsigned TASK_SLOTS = 2;

	// Widths fixed by the interface
	localparam int unsigned NOW_BITS    = 32;
	localparam int unsigned PERIOD_BITS = 16;
	localparam int unsigned CFG_IDX_BITS = 2;

	// Registration counter: ticks run only at READY, saturates at MAX
	localparam logic [1:0] COUNT_READY = 2'd2;
	localparam logic [1:0] COUNT_MAX   = 2'd3;

	// Reset periods of the two slots
	localparam logic [PERIOD_BITS-1:0] PERIOD_FIRST_RST  = 16'd100;
	localparam logic [PERIOD_BITS-1:0] PERIOD_SECOND_RST = 16'd200;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_PERIOD_FIRST  = 2'd0,
		REG_PERIOD_SECOND = 2'd1
	} reg_idx_t;

	// Input transaction kinds
	typedef enum logic [0:0] {
		OP_CREATED = 1'b0,
		OP_TICK    = 1'b1
	} op_t;

	// Per-slot status seen by the selection logic
	typedef struct packed {
		logic step;      // tick pass updates the slot this cycle
		logic eligible;  // released by now with a deadline below all-ones
	} slot_status_t;

endpackage

[hdl/periodic_edf_task_selector.sv]
// Periodic EDF task selector, top level. Depends on pedf_pkg and pedf_slot.
// A tick transaction's result reaches out_valid through the input register, then the
// result register; both slots update in parallel.
// Throughput: one transaction per cycle; input stalls only while a result waits.
// Reset: arst_n clears the registration count, slot state and pipeline valids,
// and restores the periods to 100 and 200.
module periodic_edf_task_selector #(
	parameter int unsigned TICK_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic [pedf_pkg::NOW_BITS-1:0]       now,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                chosen_task,
	input  logic                                cfg_wr_en,
	input  logic [pedf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [pedf_pkg::PERIOD_BITS-1:0]    cfg_wdata
);
	import pedf_pkg::*;

	logic [PERIOD_BITS-1:0] period_first_q;
	logic [PERIOD_BITS-1:0] period_second_q;
	logic [1:0]             reg_count_q;

	logic                   valid_s1;
	op_t                    op_s1;
	logic [TICK_BITS-1:0]   now_s1;
	logic                   out_valid_q;
	logic                   chosen_q;

	logic                   advance;
	logic                   accept_in;
	logic                   tick_go;
	logic                   created_go;
	logic                   pick_second;
	logic [63:0]            now_wide;
	logic [TICK_BITS-1:0]   now_tick;

	slot_status_t           status0;
	slot_status_t           status1;
	logic [TICK_BITS-1:0]   deadline0;
	logic [TICK_BITS-1:0]   deadline1;

	// Handshake: input register moves on unless a result is held
	assign advance   = !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign accept_in = in_valid && !in_stall;

	assign tick_go    = valid_s1 && advance && (op_s1 == OP_TICK)
	                    && (reg_count_q == COUNT_READY);
	assign created_go = valid_s1 && advance && (op_s1 == OP_CREATED);

	// Fit the incoming tick count to the tick width
	assign now_wide = {{(64 - NOW_BITS){1'b0}}, now};
	assign now_tick = now_wide[TICK_BITS-1:0];

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_first_q  <= PERIOD_FIRST_RST;
			period_second_q <= PERIOD_SECOND_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PERIOD_FIRST:  period_first_q  <= cfg_wdata;
				REG_PERIOD_SECOND: period_second_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register: valid bit under reset, payload without
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			op_s1  <= op_t'(op);
			now_s1 <= now_tick;
		end
	end

	// Count task registrations, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_count_q <= '0;
		end else if (created_go && (reg_count_q != COUNT_MAX)) begin
			reg_count_q <= reg_count_q + 2'd1;
		end
	end

	// Task slots
	pedf_slot #(.TICK_BITS(TICK_BITS)) u_slot0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (tick_go),
		.now      (now_s1),
		.period   (period_first_q),
		.status   (status0),
		.deadline (deadline0)
	);

	pedf_slot #(.TICK_BITS(TICK_BITS)) u_slot1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (tick_go),
		.now      (now_s1),
		.period   (period_second_q),
		.status   (status1),
		.deadline (deadline1)
	);

	// Earliest deadline wins; the lower slot takes a tie
	assign pick_second = status1.eligible && (!status0.eligible || (deadline1 < deadline0));

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= status0.step && (status0.eligible || status1.eligible);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			chosen_q <= pick_second;
		end
	end

	assign out_valid   = out_valid_q;
	assign chosen_task = chosen_q;

endmodule

[hdl/pedf_slot.sv]
// One task slot: release and deadline state with its update on a tick pass.
// Depends on pedf_pkg.
module pedf_slot #(
	parameter int unsigned TICK_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic [TICK_BITS-1:0]                now,
	input  logic [pedf_pkg::PERIOD_BITS-1:0]    period,
	output pedf_pkg::slot_status_t              status,
	output logic [TICK_BITS-1:0]                deadline
);
	import pedf_pkg::*;

	localparam logic [TICK_BITS-1:0] TICK_ALL_ONES = {TICK_BITS{1'b1}};

	logic                 started_q;
	logic [TICK_BITS-1:0] release_q;
	logic [TICK_BITS-1:0] deadline_q;
	logic [TICK_BITS-1:0] period_ext;
	logic [TICK_BITS-1:0] release_next;
	logic [TICK_BITS-1:0] deadline_next;
	logic                 rerelease;
	logic [63:0]          period_wide;

	// Widen the period to the tick width
	assign period_wide = {{(64 - PERIOD_BITS){1'b0}}, period};
	assign period_ext  = period_wide[TICK_BITS-1:0];

	// Release on the first tick, or again once the period has run out
	always_comb begin
		rerelease     = !started_q || (now > (release_q + period_ext));
		release_next  = rerelease ? now : release_q;
		deadline_next = rerelease ? (now + period_ext) : deadline_q;
	end

	// Report the updated view so a tick selects on its own update
	assign status.step     = step;
	assign status.eligible = (release_next <= now) && (deadline_next < TICK_ALL_ONES);
	assign deadline        = deadline_next;

	// Hold slot state between tick passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q  <= 1'b0;
			release_q  <= '0;
			deadline_q <= '0;
		end else if (step) begin
			started_q  <= 1'b1;
			release_q  <= release_next;
			deadline_q <= deadline_next;
		end
	end

endmodule

[hdl/pedf_checker.sv]
// Port-level checks for the periodic EDF task selector, bound to its top level.
// Depends on pedf_pkg and periodic_edf_task_selector.
module pedf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic op,
	input logic out_valid,
	input logic out_stall,
	input logic chosen_task
);
	import pedf_pkg::*;

	// A stalled result holds its slot
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(chosen_task)))
		else $error("result changed while stalled");

	// Input stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	// A created transaction that moves straight through yields no result
	a_created_silent: assert property (@(posedge clk) disable iff (!arst_n)
		($past(in_valid && !in_stall && (op == OP_CREATED), 2)
		 && $past(!(out_valid && out_stall))) |-> !out_valid)
		else $error("result from a created transaction");

endmodule

bind periodic_edf_task_selector pedf_checker u_pedf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.op          (op),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.chosen_task (chosen_task)
);

[sim/tb_periodic_edf_task_selector.sv]
`timescale 1ns / 1ps
// Self-checking bench for periodic_edf_task_selector: directed table, then random tick streams
// under several period settings and idle/stall mixes. Depends on pedf_pkg and the block's RTL.
module tb_periodic_edf_task_selector;
	import pedf_pkg::*;

	localparam int unsigned QUIET_LIMIT   = 5000;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned PHASE_ITEMS   = 230;
	localparam int unsigned NUM_PHASES    = 8;
	localparam int unsigned TAIL_ITEMS    = 40;

	// One row of the directed table; typed rows carry their own expected outcome
	typedef struct {
		op_t                 kind;
		logic [NOW_BITS-1:0] t;
		bit                  typed;
		bit                  hit;
		bit                  slot;
	} tick_row_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	op_t                    op        = OP_CREATED;
	logic [NOW_BITS-1:0]    now       = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   chosen_task;
	logic                   cfg_wr_en = 1'b0;
	reg_idx_t               cfg_index = REG_PERIOD_FIRST;
	logic [PERIOD_BITS-1:0] cfg_wdata = '0;

	// Scheduler state mirrored by the bench
	logic [PERIOD_BITS-1:0] slot_period   [TASK_SLOTS];
	logic [1:0]             reg_count;
	bit                     slot_started  [TASK_SLOTS];
	logic [NOW_BITS-1:0]    slot_release  [TASK_SLOTS];
	logic [NOW_BITS-1:0]    slot_deadline [TASK_SLOTS];

	bit                  expected_slot_q [$];
	tick_row_t           tick_rows [$];
	logic [NOW_BITS-1:0] tick_clock;
	int unsigned         sender_idle_pct    = 0;
	int unsigned         receiver_stall_pct = 0;
	int unsigned         fail_count         = 0;
	int unsigned         results_checked    = 0;
	int unsigned         items_sent         = 0;
	int unsigned         quiet_cycles       = 0;

	periodic_edf_task_selector uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.now        (now),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.chosen_task(chosen_task),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Advance the EDF state by one transaction and report the slot it triggers, if any
	task automatic edf_step(input op_t kind, input logic [NOW_BITS-1:0] t,
			output bit hit, output bit slot);
		logic [NOW_BITS-1:0] lapse;
		logic [NOW_BITS-1:0] best;
		hit  = 1'b0;
		slot = 1'b0;
		if (kind == OP_CREATED) begin
			if (reg_count != COUNT_MAX)
				reg_count = reg_count + 2'd1;
		end else if (reg_count == COUNT_READY) begin
			// release on the first tick, re-release once the period has lapsed
			for (int i = 0; i < TASK_SLOTS; i++) begin
				lapse = slot_release[i] + slot_period[i];
				if (!slot_started[i] || t > lapse) begin
					slot_started[i]  = 1'b1;
					slot_release[i]  = t;
					slot_deadline[i] = t + slot_period[i];
				end
			end
			// earliest deadline among released slots, lower slot on a tie
			best = '1;
			for (int i = 0; i < TASK_SLOTS; i++) begin
				if (slot_release[i] <= t && slot_deadline[i] < best) begin
					best = slot_deadline[i];
					slot = i[0];
					hit  = 1'b1;
				end
			end
		end
	endtask

	task automatic add_row(input op_t kind, input logic [NOW_BITS-1:0] t,
			input bit typed, input bit hit, input bit slot);
		tick_row_t row;
		row.kind  = kind;
		row.t     = t;
		row.typed = typed;
		row.hit   = hit;
		row.slot  = slot;
		tick_rows.push_back(row);
	endtask

	// Drive one transaction from a falling edge and hold it until accepted
	task automatic send_item(input op_t kind, input logic [NOW_BITS-1:0] t,
			input bit typed, input bit typed_hit, input bit typed_slot);
		bit hit;
		bit slot;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op       <= kind;
		now      <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		edf_step(kind, t, hit, slot);
		if (typed) begin
			hit  = typed_hit;
			slot = typed_slot;
		end
		if (hit)
			expected_slot_q.push_back(slot);
		items_sent++;
		@(negedge clk);
	endtask

	// Drain, let the pipeline settle, then write both periods
	task automatic load_periods(input logic [PERIOD_BITS-1:0] p_first,
			input logic [PERIOD_BITS-1:0] p_second);
		while (expected_slot_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_PERIOD_FIRST;
		cfg_wdata <= p_first;
		@(negedge clk);
		cfg_index <= REG_PERIOD_SECOND;
		cfg_wdata <= p_second;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		slot_period[0] = p_first;
		slot_period[1] = p_second;
	endtask

	// Pick the next tick time: mostly forward steps, some period boundaries, jumps and wraps
	function automatic logic [NOW_BITS-1:0] next_tick_time();
		int unsigned span;
		int unsigned pick;
		int unsigned s;
		span = (slot_period[0] > slot_period[1]) ? 32'(slot_period[0]) : 32'(slot_period[1]);
		span = span + span / 2 + 2;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			tick_clock = tick_clock + $urandom_range(0, span);
		end else if (pick < 80) begin
			s = $urandom_range(0, 1);
			tick_clock = slot_release[s] + slot_period[s] + $urandom_range(0, 1);
		end else if (pick < 88) begin
			tick_clock = $urandom;
		end else if (pick < 94) begin
			tick_clock = '1 - $urandom_range(0, span);
		end else begin
			tick_clock = tick_clock - $urandom_range(0, span);
		end
		return tick_clock;
	endfunction

	// Randomise the receiver's back-pressure
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
	end

	// Check results in order and watch for a hung handshake
	always @(posedge clk) begin
		bit expected;
		if (out_valid && !out_stall) begin
			if (expected_slot_q.size() == 0) begin
				$error("chosen_task: no result expected, got %0d", chosen_task);
				fail_count++;
			end else begin
				expected = expected_slot_q.pop_front();
				if (chosen_task !== expected) begin
					$error("chosen_task: expected %0d, got %0d", expected, chosen_task);
					fail_count++;
				end
				results_checked++;
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", quiet_cycles);
			$display("FAIL periodic_edf_task_selector");
			$finish;
		end
	end

	initial begin
		// mirror the reset state
		slot_period[0] = PERIOD_FIRST_RST;
		slot_period[1] = PERIOD_SECOND_RST;
		reg_count      = '0;
		for (int i = 0; i < TASK_SLOTS; i++) begin
			slot_started[i]  = 1'b0;
			slot_release[i]  = '0;
			slot_deadline[i] = '0;
		end
		tick_clock = '0;

		// directed table, reset periods 100 and 200
		add_row(OP_TICK,    32'h0000_0000, 1'b1, 1'b0, 1'b0); // tick before registration
		add_row(OP_CREATED, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0); // created never reports
		add_row(OP_TICK,    32'h0000_0005, 1'b1, 1'b0, 1'b0); // one slot only: still idle
		add_row(OP_CREATED, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
		add_row(OP_TICK,    32'h0000_0000, 1'b1, 1'b1, 1'b0); // first release at time zero
		add_row(OP_TICK,    32'h0000_0032, 1'b1, 1'b1, 1'b0);
		add_row(OP_TICK,    32'h0000_0065, 1'b0, 1'b0, 1'b0); // slot zero re-released
		add_row(OP_TICK,    32'h0000_00C9, 1'b0, 1'b0, 1'b0); // slot one re-released
		add_row(OP_TICK,    32'h0000_0064, 1'b0, 1'b0, 1'b0); // time before both releases
		add_row(OP_TICK,    32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0); // deadlines wrap past zero
		add_row(OP_TICK,    32'h0000_0000, 1'b0, 1'b0, 1'b0);
		add_row(OP_TICK,    32'hFFFF_FF00, 1'b0, 1'b0, 1'b0);
		add_row(OP_TICK,    32'hFFFF_FF9B, 1'b0, 1'b0, 1'b0); // deadline lands on all-ones
		add_row(OP_TICK,    32'hAAAA_5555, 1'b0, 1'b0, 1'b0);
		add_row(OP_TICK,    32'h5555_AAAA, 1'b0, 1'b0, 1'b0);

		// hold reset, then release on a falling edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (tick_rows[r])
			send_item(tick_rows[r].kind, tick_rows[r].t, tick_rows[r].typed,
				tick_rows[r].hit, tick_rows[r].slot);

		// random tick streams, one period setting and idle mix per phase
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph % 4)
				0: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct    = 75;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 75;
				end
				default: begin
					sender_idle_pct    = 28;
					receiver_stall_pct = 28;
				end
			endcase
			case (ph)
				1: load_periods(16'd1, 16'hFFFF);
				2: load_periods(16'hFFFF, 16'd1);
				3: load_periods(16'd0, 16'd0);
				4: load_periods(16'd37, 16'd37);
				5: load_periods(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
				6: load_periods(16'hFFFF, 16'hFFFF);
				7: load_periods(16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)));
				default: ;
			endcase
			repeat (PHASE_ITEMS)
				send_item(OP_TICK, next_tick_time(), 1'b0, 1'b0, 1'b0);
			in_valid <= 1'b0;
		end

		// extra registration saturates the count; every later tick is dropped
		send_item(OP_CREATED, $urandom, 1'b0, 1'b0, 1'b0);
		repeat (TAIL_ITEMS)
			send_item(($urandom_range(0, 3) == 0) ? OP_CREATED : OP_TICK, next_tick_time(),
				1'b0, 1'b0, 1'b0);
		in_valid <= 1'b0;

		// drain and let the pipeline settle
		while (expected_slot_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d transactions across %0d period settings and four idle/stall mixes,",
			items_sent, NUM_PHASES);
		$display("ending with saturated registration; %0d chosen slots checked, %0d mismatches.",
			results_checked, fail_count);
		if (fail_count == 0)
			$display("PASS periodic_edf_task_selector");
		else
			$display("FAIL periodic_edf_task_selector");
		$finish;
	end

endmodule
